@@ hw/rtl/wth_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wth_pkg
// Types, constants and the hash step shared by the word tokenizer and hasher.
// ----------------------------------------------------------------------------
package wth_pkg;

    localparam int NUM_BRK = 5;

    // Depth of the queue between front and back end.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam logic [QAW:0] QCNT_FULL = (QAW + 1)'(QDEPTH);

    typedef enum logic [1:0] {
        TOK_SPACE = 2'd0,
        TOK_WORD  = 2'd1,
        TOK_BREAK = 2'd2,
        TOK_END   = 2'd3
    } t_tok_kind;

    typedef enum logic [2:0] {
        REG_CASE_SENS = 3'd0,
        REG_BRK_ON    = 3'd1,
        REG_BRK_CNT   = 3'd2,
        REG_BRK_A     = 3'd3,
        REG_BRK_B     = 3'd4,
        REG_BRK_C     = 3'd5,
        REG_BRK_D     = 3'd6,
        REG_BRK_E     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic                       case_sens;
        logic                       brk_on;
        logic [2:0]                 brk_cnt;
        logic [NUM_BRK-1:0][7:0]    brk_chr;
    } t_cfg;

    localparam logic       RST_CASE_SENS = 1'b1;
    localparam logic       RST_BRK_ON    = 1'b0;
    localparam logic [2:0] RST_BRK_CNT   = 3'd4;
    localparam logic [7:0] RST_BRK_A     = 8'd44;
    localparam logic [7:0] RST_BRK_B     = 8'd46;
    localparam logic [7:0] RST_BRK_C     = 8'd59;
    localparam logic [7:0] RST_BRK_D     = 8'd58;
    localparam logic [7:0] RST_BRK_E     = 8'd0;

    // One classified item as it travels from front to back end.
    typedef struct packed {
        logic        eol;
        logic        space;
        logic        brk;
        logic [15:0] ch;     // already case folded when folding is on
        logic [16:0] pos;
        logic        ovf;    // meaningful on end of line only
    } t_cls_item;

    typedef struct packed {
        t_tok_kind   kind;
        logic [15:0] start;
        logic [15:0] stop;
        logic [31:0] hash;
        logic        last;
        logic        ovf;
    } t_token;

    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [15:0] c);
        return h + {16'b0, c} + {h[24:0], h[31:25]} + h;
    endfunction

endpackage

@@ hw/rtl/word_tokenizer_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_tokenizer_hasher
// Splits a stream of 16-bit characters into whitespace runs, words and break
// tokens, each reported with its first and last position and a 32-bit hash.
// ----------------------------------------------------------------------------
// One character or end-of-line transfer is taken per clock cycle while the
// queue is not full. A character that both closes an open run and forms a
// break token yields two results, and the back end then keeps it at the queue
// head until both are out, since the result register delivers one token per
// cycle when the output is not stalled. A four-entry queue between the
// classifying front end and the token back end absorbs such pairs and short
// output stalls. Characters at or past the line limit are dropped and flagged
// on the end-of-line result. No clearing pass is needed after reset.
module word_tokenizer_hasher #(
    parameter int LINE_CHARS  = 65536,
    parameter int BREAK_SLOTS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Character stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] char_code
    input  logic        i_s_tlast,   // kind: 1 = end of line
    // Token stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [15:0] token_start, [31:16] token_end,
                                     // [63:32] token_hash, [64] overflow
    output logic [1:0]  o_m_tuser,   // [1:0] token_kind
    output logic        o_m_tlast,   // last
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    wth_pkg::t_cfg      r_cfg;
    wth_pkg::t_reg_idx  reg_idx;
    wth_pkg::t_cls_item front_item;
    wth_pkg::t_cls_item q_item;
    wth_pkg::t_token    tok;
    logic               cfg_wr;
    logic               q_full;
    logic               q_push;
    logic               q_valid;
    logic               q_pop;

    assign pready  = 1'b1;
    assign reg_idx = wth_pkg::t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.case_sens  <= wth_pkg::RST_CASE_SENS;
            r_cfg.brk_on     <= wth_pkg::RST_BRK_ON;
            r_cfg.brk_cnt    <= wth_pkg::RST_BRK_CNT;
            r_cfg.brk_chr[0] <= wth_pkg::RST_BRK_A;
            r_cfg.brk_chr[1] <= wth_pkg::RST_BRK_B;
            r_cfg.brk_chr[2] <= wth_pkg::RST_BRK_C;
            r_cfg.brk_chr[3] <= wth_pkg::RST_BRK_D;
            r_cfg.brk_chr[4] <= wth_pkg::RST_BRK_E;
        end else if (cfg_wr) begin
            case (reg_idx)
                wth_pkg::REG_CASE_SENS: r_cfg.case_sens  <= pwdata[0];
                wth_pkg::REG_BRK_ON:    r_cfg.brk_on     <= pwdata[0];
                wth_pkg::REG_BRK_CNT:   r_cfg.brk_cnt    <= pwdata[2:0];
                wth_pkg::REG_BRK_A:     r_cfg.brk_chr[0] <= pwdata[7:0];
                wth_pkg::REG_BRK_B:     r_cfg.brk_chr[1] <= pwdata[7:0];
                wth_pkg::REG_BRK_C:     r_cfg.brk_chr[2] <= pwdata[7:0];
                wth_pkg::REG_BRK_D:     r_cfg.brk_chr[3] <= pwdata[7:0];
                wth_pkg::REG_BRK_E:     r_cfg.brk_chr[4] <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            wth_pkg::REG_CASE_SENS: prdata = {31'b0, r_cfg.case_sens};
            wth_pkg::REG_BRK_ON:    prdata = {31'b0, r_cfg.brk_on};
            wth_pkg::REG_BRK_CNT:   prdata = {29'b0, r_cfg.brk_cnt};
            wth_pkg::REG_BRK_A:     prdata = {24'b0, r_cfg.brk_chr[0]};
            wth_pkg::REG_BRK_B:     prdata = {24'b0, r_cfg.brk_chr[1]};
            wth_pkg::REG_BRK_C:     prdata = {24'b0, r_cfg.brk_chr[2]};
            wth_pkg::REG_BRK_D:     prdata = {24'b0, r_cfg.brk_chr[3]};
            wth_pkg::REG_BRK_E:     prdata = {24'b0, r_cfg.brk_chr[4]};
            default:                prdata = '0;
        endcase
    end

    wth_front #(
        .LINE_CHARS  (LINE_CHARS),
        .BREAK_SLOTS (BREAK_SLOTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_tvalid),
        .i_eol    (i_s_tlast),
        .i_char   (i_s_tdata),
        .o_ready  (o_s_tready),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (front_item)
    );

    wth_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    wth_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_tok_valid (o_m_tvalid),
        .o_tok       (tok),
        .i_tok_ready (i_m_tready)
    );

    assign o_m_tdata = {7'b0, tok.ovf, tok.hash, tok.stop, tok.start};
    assign o_m_tuser = tok.kind;
    assign o_m_tlast = tok.last;

endmodule

@@ hw/rtl/wth_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wth_front
// Accepts characters, numbers them, drops those past the line limit and
// classifies the rest as whitespace, break or word character.
// ----------------------------------------------------------------------------
module wth_front #(
    parameter int LINE_CHARS  = 65536,
    parameter int BREAK_SLOTS = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wth_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  logic              i_eol,
    input  logic [15:0]       i_char,
    output logic              o_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output wth_pkg::t_cls_item o_item
);

    localparam int LIMIT_INT = (LINE_CHARS > 65536) ? 65536 : LINE_CHARS;
    localparam logic [16:0] LIMIT = 17'(LIMIT_INT);
    localparam int NSLOT_INT = (BREAK_SLOTS < wth_pkg::NUM_BRK) ? BREAK_SLOTS : wth_pkg::NUM_BRK;
    localparam logic [2:0] NSLOT = 3'(NSLOT_INT);

    logic [16:0] r_pos, n_pos;
    logic        r_ovf, n_ovf;
    logic        accept;
    logic        drop;
    logic [2:0]  cnt_eff;
    logic        slot_hit;
    logic        is_space;
    logic        is_brk;
    logic [15:0] folded;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign drop    = !i_eol && (r_pos >= LIMIT);
    assign o_push  = accept && !drop;

    always_comb begin
        cnt_eff  = (i_cfg.brk_cnt > NSLOT) ? NSLOT : i_cfg.brk_cnt;
        slot_hit = 1'b0;
        for (int i = 0; i < wth_pkg::NUM_BRK; i++) begin
            if ((3'(i) < cnt_eff) && (i_char == {8'b0, i_cfg.brk_chr[i]})) begin
                slot_hit = 1'b1;
            end
        end
        is_space = (i_char == 16'h0020) || (i_char inside {[16'h0009:16'h000D]});
        is_brk   = (|i_char[15:8]) || (i_cfg.brk_on && ((i_char == 16'h0000) || slot_hit));
        if (!i_cfg.case_sens && (i_char inside {[16'h0061:16'h007A]})) begin
            folded = i_char - 16'h0020;
        end else begin
            folded = i_char;
        end
    end

    always_comb begin
        o_item.eol   = i_eol;
        o_item.space = is_space;
        o_item.brk   = is_brk;
        o_item.ch    = folded;
        o_item.pos   = r_pos;
        o_item.ovf   = r_ovf;
    end

    always_comb begin
        n_pos = r_pos;
        n_ovf = r_ovf;
        if (accept) begin
            if (i_eol) begin
                n_pos = '0;
                n_ovf = 1'b0;
            end else if (drop) begin
                n_ovf = 1'b1;
            end else begin
                n_pos = r_pos + 17'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_ovf <= n_ovf;
        end
    end

endmodule

@@ hw/rtl/wth_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wth_queue
// Short first-in first-out queue of classified items between the two ends.
// ----------------------------------------------------------------------------
module wth_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wth_pkg::t_cls_item i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output wth_pkg::t_cls_item o_item
);

    wth_pkg::t_cls_item r_mem [wth_pkg::QDEPTH];
    logic [wth_pkg::QAW-1:0] r_wr, n_wr;
    logic [wth_pkg::QAW-1:0] r_rd, n_rd;
    logic [wth_pkg::QAW:0]   r_cnt, n_cnt;
    logic                    do_push;
    logic                    do_pop;

    assign o_full  = (r_cnt == wth_pkg::QCNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/wth_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wth_back
// Token tracker: keeps the open run and its hash, forms up to two tokens per
// classified item; its result register hands one out per cycle unless stalled.
// ----------------------------------------------------------------------------
module wth_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  wth_pkg::t_cls_item i_item,
    output logic               o_pop,
    output logic               o_tok_valid,
    output wth_pkg::t_token    o_tok,
    input  logic               i_tok_ready
);

    logic        r_in_word, n_in_word;
    logic [16:0] r_run_start, n_run_start;
    logic [31:0] r_hash, n_hash;
    logic        r_phase, n_phase;
    logic        r_out_valid, n_out_valid;
    wth_pkg::t_token r_out;

    logic            rs_lt_p;
    logic            has_a;
    logic            has_b;
    logic            out_free;
    logic            emit;
    logic            finish;
    logic [16:0]     pos_m1;
    logic [31:0]     h_base;
    logic [31:0]     h_next;
    logic [31:0]     h_brk;
    wth_pkg::t_token res_a;
    wth_pkg::t_token res_b;
    wth_pkg::t_token cur;

    assign rs_lt_p  = r_run_start < i_item.pos;
    assign pos_m1   = i_item.pos - 17'd1;
    assign out_free = !r_out_valid || i_tok_ready;

    // The open run closes at line end or when a character cannot extend it.
    always_comb begin
        has_a = i_item.eol || (rs_lt_p &&
                (i_item.space ? r_in_word : (!r_in_word || i_item.brk)));
        has_b = !i_item.eol && !i_item.space && i_item.brk;
    end

    always_comb begin
        h_brk  = wth_pkg::hash_step(32'd0, i_item.ch);
        h_base = (i_item.space ? r_in_word : !r_in_word) ? 32'd0 : r_hash;
        h_next = wth_pkg::hash_step(h_base, i_item.ch);
    end

    always_comb begin
        if (i_item.eol && !rs_lt_p) begin
            res_a.kind  = wth_pkg::TOK_END;
            res_a.start = '0;
            res_a.stop  = '0;
            res_a.hash  = '0;
        end else begin
            res_a.kind  = r_in_word ? wth_pkg::TOK_WORD : wth_pkg::TOK_SPACE;
            res_a.start = r_run_start[15:0];
            res_a.stop  = pos_m1[15:0];
            res_a.hash  = r_hash;
        end
        res_a.last = i_item.eol;
        res_a.ovf  = i_item.eol && i_item.ovf;

        res_b.kind  = wth_pkg::TOK_BREAK;
        res_b.start = i_item.pos[15:0];
        res_b.stop  = i_item.pos[15:0];
        res_b.hash  = h_brk;
        res_b.last  = 1'b0;
        res_b.ovf   = 1'b0;

        cur = (has_a && !r_phase) ? res_a : res_b;
    end

    // An item with two tokens stays at the queue head until both are emitted.
    always_comb begin
        emit   = i_valid && (has_a || has_b) && out_free;
        finish = i_valid && (!(has_a || has_b) ||
                 (out_free && (!(has_a && has_b) || r_phase)));
    end

    assign o_pop       = finish;
    assign o_tok_valid = r_out_valid;
    assign o_tok       = r_out;

    always_comb begin
        n_in_word   = r_in_word;
        n_run_start = r_run_start;
        n_hash      = r_hash;
        if (finish) begin
            if (i_item.eol) begin
                n_in_word   = 1'b0;
                n_run_start = '0;
                n_hash      = '0;
            end else if (i_item.space) begin
                n_in_word = 1'b0;
                if (r_in_word) begin
                    n_run_start = i_item.pos;
                end
                n_hash = h_next;
            end else if (i_item.brk) begin
                n_in_word   = 1'b1;
                n_run_start = i_item.pos + 17'd1;
                n_hash      = '0;
            end else begin
                n_in_word = 1'b1;
                if (!r_in_word) begin
                    n_run_start = i_item.pos;
                end
                n_hash = h_next;
            end
        end

        if (finish) begin
            n_phase = 1'b0;
        end else if (emit) begin
            n_phase = 1'b1;
        end else begin
            n_phase = r_phase;
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_tok_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word   <= 1'b0;
            r_run_start <= '0;
            r_hash      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_word   <= n_in_word;
            r_run_start <= n_run_start;
            r_hash      <= n_hash;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hw/rtl/wth_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wth_checker
// Port-level checks on the token stream of the word tokenizer and hasher.
// ----------------------------------------------------------------------------
module wth_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] o_m_tdata,
    input  logic [1:0]  o_m_tuser,
    input  logic        o_m_tlast
);

    // Nothing is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("token offered right after reset");

    // The end marker only ever closes a line and carries zero fields.
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == wth_pkg::TOK_END))
        |-> (o_m_tlast && (o_m_tdata[63:0] == 64'd0)))
        else $error("malformed end marker");

    // Dropped characters are reported on the closing token only.
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[64]) |-> o_m_tlast)
        else $error("overflow flag on a token that does not close the line");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != wth_pkg::TOK_END))
        |-> (o_m_tdata[15:0] <= o_m_tdata[31:16]))
        else $error("token ends before it starts");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_m_tvalid && !i_m_tready))
        |-> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)
             && $stable(o_m_tlast)))
        else $error("stalled token changed or vanished");

endmodule

bind word_tokenizer_hasher wth_checker u_wth_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
